@@ rtl/osc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc_pkg: output script template classifier definitions
// Opcodes, template geometry, class codes and dust thresholds.
// ----------------------------------------------------------------------------
package osc_pkg;

  localparam int NumStrict = 7;
  localparam int NumLoose  = 5;

  localparam logic [6:0] POS_MAX    = 7'd127;
  localparam logic [6:0] STRICT_ALL = 7'h7f;
  localparam logic [4:0] LOOSE_ALL  = 5'h1f;

  // Template indexes (class code is index + 1)
  localparam logic [2:0] TPL_KEYHASH    = 3'd0;
  localparam logic [2:0] TPL_SCRIPTHASH = 3'd1;
  localparam logic [2:0] TPL_WKEYHASH   = 3'd2;
  localparam logic [2:0] TPL_WSCRIPT    = 3'd3;
  localparam logic [2:0] TPL_TAPROOT    = 3'd4;
  localparam logic [2:0] TPL_KEY33      = 3'd5;
  localparam logic [2:0] TPL_KEY65      = 3'd6;

  localparam logic [2:0] CLS_NONE = 3'd0;

  // Opcodes and push lengths
  localparam logic [7:0] OPC_0           = 8'h00;
  localparam logic [7:0] OPC_1           = 8'h51;
  localparam logic [7:0] OPC_DUP         = 8'h76;
  localparam logic [7:0] OPC_EQUAL       = 8'h87;
  localparam logic [7:0] OPC_EQUALVERIFY = 8'h88;
  localparam logic [7:0] OPC_HASH160     = 8'ha9;
  localparam logic [7:0] OPC_CHECKSIG    = 8'hac;
  localparam logic [7:0] PUSH_20         = 8'd20;
  localparam logic [7:0] PUSH_32         = 8'd32;
  localparam logic [7:0] PUSH_33         = 8'd33;
  localparam logic [7:0] PUSH_65         = 8'd65;
  localparam logic [7:0] KEY_EVEN        = 8'h02;
  localparam logic [7:0] KEY_ODD         = 8'h03;
  localparam logic [7:0] KEY_FULL        = 8'h04;

  // Template geometry: total length and payload span
  localparam logic [6:0] TMPL_LEN  [NumStrict] = '{7'd25, 7'd23, 7'd22, 7'd34,
                                                  7'd34, 7'd35, 7'd67};
  localparam logic [6:0] PAY_FIRST [NumStrict] = '{7'd3, 7'd2, 7'd2, 7'd2,
                                                  7'd2, 7'd1, 7'd1};
  localparam logic [6:0] PAY_LAST  [NumStrict] = '{7'd22, 7'd21, 7'd21, 7'd33,
                                                  7'd33, 7'd33, 7'd65};

  // Dust thresholds in satoshi
  localparam logic [9:0] DUST_DEFAULT = 10'd546;
  localparam logic [9:0] DUST_OF [NumLoose] = '{10'd546, 10'd540, 10'd294,
                                                10'd330, 10'd330};

endpackage
`default_nettype wire

@@ rtl/output_script_template_classifier_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// output_script_template_classifier_core: standard output script classifier
// Streams a script byte by byte, echoes each byte with a payload flag and
// gives template class and dust threshold on the last byte.
// ----------------------------------------------------------------------------
// Each accepted byte gives its result beat in the next cycle.
// Throughput: 1 byte per cycle; the single result register is refilled in
//   the cycle it is drained, so input stalls only while the output stalls.
// Reset: position clears to 0, all match flags set, result register empty.
// ----------------------------------------------------------------------------
module output_script_template_classifier_core (
  input  wire logic       clk,
  input  wire logic       rst,
  // script byte channel
  input  wire logic       script_valid,
  output logic            script_stall,
  input  wire logic [7:0] script_byte,
  input  wire logic       last_byte,
  // result channel
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      byte_echo,
  output logic            in_payload,
  output logic            end_of_script,
  output logic [2:0]      script_class,
  output logic [9:0]      dust_limit
);

  // Leading-byte check shared by strict and loose matching
  function automatic logic prefix_ok(input logic [2:0] t, input logic [6:0] p,
                                     input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    unique case (t)
      osc_pkg::TPL_KEYHASH: begin
        if (p == 7'd0) ok = (b == osc_pkg::OPC_DUP);
        else if (p == 7'd1) ok = (b == osc_pkg::OPC_HASH160);
        else if (p == 7'd2) ok = (b == osc_pkg::PUSH_20);
        else ok = 1'b1;
      end
      osc_pkg::TPL_SCRIPTHASH: begin
        if (p == 7'd0) ok = (b == osc_pkg::OPC_HASH160);
        else if (p == 7'd1) ok = (b == osc_pkg::PUSH_20);
        else ok = 1'b1;
      end
      osc_pkg::TPL_WKEYHASH: begin
        if (p == 7'd0) ok = (b == osc_pkg::OPC_0);
        else if (p == 7'd1) ok = (b == osc_pkg::PUSH_20);
        else ok = 1'b1;
      end
      osc_pkg::TPL_WSCRIPT: begin
        if (p == 7'd0) ok = (b == osc_pkg::OPC_0);
        else if (p == 7'd1) ok = (b == osc_pkg::PUSH_32);
        else ok = 1'b1;
      end
      osc_pkg::TPL_TAPROOT: begin
        if (p == 7'd0) ok = (b == osc_pkg::OPC_1);
        else if (p == 7'd1) ok = (b == osc_pkg::PUSH_32);
        else ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Full check at one position, including trailing opcodes and bare keys
  function automatic logic strict_ok(input logic [2:0] t, input logic [6:0] p,
                                     input logic [7:0] b);
    logic ok;
    ok = prefix_ok(t, p, b);
    unique case (t)
      osc_pkg::TPL_KEYHASH: begin
        if (p == 7'd23) ok = (b == osc_pkg::OPC_EQUALVERIFY);
        else if (p == 7'd24) ok = (b == osc_pkg::OPC_CHECKSIG);
      end
      osc_pkg::TPL_SCRIPTHASH: begin
        if (p == 7'd22) ok = (b == osc_pkg::OPC_EQUAL);
      end
      osc_pkg::TPL_KEY33: begin
        if (p == 7'd0) ok = (b == osc_pkg::PUSH_33);
        else if (p == 7'd1) ok = (b == osc_pkg::KEY_EVEN) || (b == osc_pkg::KEY_ODD);
        else if (p == 7'd34) ok = (b == osc_pkg::OPC_CHECKSIG);
        else ok = 1'b1;
      end
      osc_pkg::TPL_KEY65: begin
        if (p == 7'd0) ok = (b == osc_pkg::PUSH_65);
        else if (p == 7'd1) ok = (b == osc_pkg::KEY_FULL);
        else if (p == 7'd66) ok = (b == osc_pkg::OPC_CHECKSIG);
        else ok = 1'b1;
      end
      default: ;
    endcase
    return ok;
  endfunction

  // Script tracking state
  logic [6:0] byte_position;
  logic [6:0] strict_match_flags;
  logic [4:0] loose_match_flags;

  logic       accept;
  logic [6:0] strict_next;
  logic [4:0] loose_next;
  logic       payload_next;
  logic [2:0] class_next;
  logic [9:0] dust_next;
  logic [7:0] length_now;

  // Take a byte whenever the result register is empty or draining
  assign script_stall = result_valid && result_stall;
  assign accept       = script_valid && !script_stall;
  assign length_now   = {1'b0, byte_position} + 8'd1;

  // Match update, payload flag and end-of-script classification
  always_comb begin
    strict_next  = strict_match_flags;
    loose_next   = loose_match_flags;
    payload_next = 1'b0;
    class_next   = osc_pkg::CLS_NONE;
    dust_next    = '0;
    for (int t = 0; t < osc_pkg::NumStrict; t++) begin
      if (byte_position >= osc_pkg::TMPL_LEN[t] ||
          !strict_ok(3'(t), byte_position, script_byte)) begin
        strict_next[t] = 1'b0;
      end
      if (strict_next[t] && byte_position >= osc_pkg::PAY_FIRST[t] &&
          byte_position <= osc_pkg::PAY_LAST[t]) begin
        payload_next = 1'b1;
      end
    end
    for (int t = 0; t < osc_pkg::NumLoose; t++) begin
      if (byte_position >= osc_pkg::TMPL_LEN[t] ||
          !prefix_ok(3'(t), byte_position, script_byte)) begin
        loose_next[t] = 1'b0;
      end
    end
    if (last_byte) begin
      dust_next = osc_pkg::DUST_DEFAULT;
      for (int t = osc_pkg::NumStrict - 1; t >= 0; t--) begin
        if (strict_next[t] && length_now == {1'b0, osc_pkg::TMPL_LEN[t]}) begin
          class_next = 3'(t + 1);
        end
      end
      for (int t = osc_pkg::NumLoose - 1; t >= 0; t--) begin
        if (loose_next[t] && length_now == {1'b0, osc_pkg::TMPL_LEN[t]}) begin
          dust_next = osc_pkg::DUST_OF[t];
        end
      end
    end
  end

  // Advance state on each accepted beat; restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      strict_match_flags <= osc_pkg::STRICT_ALL;
      loose_match_flags  <= osc_pkg::LOOSE_ALL;
    end else if (accept) begin
      if (last_byte) begin
        byte_position      <= '0;
        strict_match_flags <= osc_pkg::STRICT_ALL;
        loose_match_flags  <= osc_pkg::LOOSE_ALL;
      end else begin
        if (byte_position != osc_pkg::POS_MAX) begin
          byte_position <= byte_position + 7'd1;
        end
        strict_match_flags <= strict_next;
        loose_match_flags  <= loose_next;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_echo     <= script_byte;
      in_payload    <= payload_next;
      end_of_script <= last_byte;
      script_class  <= class_next;
      dust_limit    <= dust_next;
    end
  end

  // Class and dust stay zero away from the end of a script
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !end_of_script |-> script_class == osc_pkg::CLS_NONE &&
                                       dust_limit == '0)
    else $error("class or dust set on a non-final beat");

  // Last byte restarts the tracker
  assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> byte_position == '0 &&
                            strict_match_flags == osc_pkg::STRICT_ALL &&
                            loose_match_flags == osc_pkg::LOOSE_ALL)
    else $error("tracker not restarted after last byte");

  // Position counts up by one per inner byte until saturation
  assert property (@(posedge clk) disable iff (rst)
    accept && !last_byte && byte_position != osc_pkg::POS_MAX |=>
      byte_position == $past(byte_position) + 7'd1)
    else $error("byte position did not advance");

  // A strict match among the first five templates implies the loose match
  assert property (@(posedge clk) disable iff (rst)
    (strict_match_flags[4:0] & ~loose_match_flags) == 5'd0)
    else $error("strict match without loose match");

  // A filled result that is stalled stays valid and blocks the input
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

endmodule
`default_nettype wire
